// ===== hdl/vcp_pkg.sv =====
// ----------------------------------------------------------------------------
// vcp_pkg: shared definitions for the colormap pixel pipeline
// Holds default sizes, register indexes and the built-in palette ROM.
// ----------------------------------------------------------------------------
package vcp_pkg;

    localparam int DEF_SAMPLE_BITS        = 32;
    localparam int DEF_FRACTION_BITS      = 16;
    localparam int DEF_MAX_PALETTE_COLORS = 12;

    localparam int CFG_INDEX_BITS = 3;
    localparam int INDEX_BITS     = 4;
    localparam int ROM_DEPTH      = 16;
    localparam int PALETTE_COUNT  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_LOW      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_HIGH     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NODATA_CHECK   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NODATA_VALUE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PALETTE_SELECT = 3'd4;

    localparam logic [2:0] PAL_DEFAULT = 3'd0;
    localparam logic [2:0] PAL_LAST    = 3'd6;

    localparam logic [7:0] BG_CHANNEL = 8'hFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam logic [INDEX_BITS-1:0] PAL_LEN [0:PALETTE_COUNT-1] =
        '{4'd5, 4'd7, 4'd3, 4'd12, 4'd12, 4'd8, 4'd9};

    localparam t_rgb PAL_ROM [0:PALETTE_COUNT-1][0:ROM_DEPTH-1] = '{
        '{24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h003380, 24'h0080FF, 24'hCCB399, 24'h339933, 24'h1A661A, 24'h808080,
          24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h0000FF, 24'hFFFFFF, 24'hFF0000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h440154, 24'h482475, 24'h414487, 24'h355F8D, 24'h2A788E, 24'h21918C,
          24'h22A884, 24'h44BF70, 24'h70D456, 24'hA4E035, 24'hD8DF26, 24'hFDE725,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h0D0887, 24'h381A9D, 24'h5C26AE, 24'h8128BB, 24'hA622BE, 24'hC316B9,
          24'hDA25AD, 24'hEA3E92, 24'hF2606D, 24'hF38546, 24'hF0AC23, 24'hFDDA20,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h9E0142, 24'hE41A1C, 24'hFD9C28, 24'hFEE05D, 24'h85C408, 24'h08918C,
          24'h08498C, 24'h4F297A, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h67001F, 24'hB2182B, 24'hF06658, 24'hFDC0BE, 24'hF7F7FB, 24'hC6DBEF,
          24'h6AA3CD, 24'h313695, 24'h050C52, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000}
    };

endpackage

// ===== hdl/value_to_colormap_pixel_top.sv =====
// ----------------------------------------------------------------------------
// value_to_colormap_pixel_top: pseudocolour lookup for raster samples
// Normalises a fixed-point sample against the configured range and returns
// the colour of the chosen palette entry, or white for background samples.
// ----------------------------------------------------------------------------
// An accepted input beat passes through the four register stages to the result beat.
// Throughput: one beat per cycle while the output is not stalled; the four register
// stages advance independently, so a stall at the output only holds the stages behind it.
// Reset: synchronous, active low; it empties the pipeline and loads the
// register defaults (range 0 to 1.0, nodata checking off, default palette).
// The configuration port is always ready.
module value_to_colormap_pixel_top #(
    parameter int SAMPLE_BITS        = vcp_pkg::DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS      = vcp_pkg::DEF_FRACTION_BITS,
    parameter int MAX_PALETTE_COLORS = vcp_pkg::DEF_MAX_PALETTE_COLORS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vcp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]             i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_not_finite,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic [vcp_pkg::INDEX_BITS-1:0]     o_color_index,
    output logic                               o_background
);
    import vcp_pkg::*;

    localparam int KMAX = MAX_PALETTE_COLORS - 1;
    localparam int PW   = SAMPLE_BITS + INDEX_BITS;
    localparam logic [INDEX_BITS:0] MAX_N = (INDEX_BITS + 1)'(MAX_PALETTE_COLORS);

    logic signed [SAMPLE_BITS-1:0] r_range_low;
    logic signed [SAMPLE_BITS-1:0] r_range_high;
    logic                          r_nodata_check;
    logic signed [SAMPLE_BITS-1:0] r_nodata_value;
    logic [2:0]                    r_palette_select;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low      <= '0;
            r_range_high     <= SAMPLE_BITS'(64'd1 << FRACTION_BITS);
            r_nodata_check   <= 1'b0;
            r_nodata_value   <= '0;
            r_palette_select <= PAL_DEFAULT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:      r_range_low      <= i_cfg_data;
                CFG_RANGE_HIGH:     r_range_high     <= i_cfg_data;
                CFG_NODATA_CHECK:   r_nodata_check   <= i_cfg_data[0];
                CFG_NODATA_VALUE:   r_nodata_value   <= i_cfg_data;
                CFG_PALETTE_SELECT: r_palette_select <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Per-stage flow control: a stage loads when it is empty or its
    // successor loads.
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic r1_valid, r2_valid, r3_valid, r4_valid;

    assign w_rdy4  = !r4_valid || !i_stall;
    assign w_rdy3  = !r3_valid || w_rdy4;
    assign w_rdy2  = !r2_valid || w_rdy3;
    assign w_rdy1  = !r1_valid || w_rdy2;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (w_rdy1) r1_valid <= i_valid;
            if (w_rdy2) r2_valid <= r1_valid;
            if (w_rdy3) r3_valid <= r2_valid;
            if (w_rdy4) r4_valid <= r3_valid;
        end
    end

    // Stage 1: classification, difference and span.
    logic [2:0]             n_sel;
    logic [INDEX_BITS:0]    n_n;
    logic [INDEX_BITS-1:0]  n_k;
    logic                   n_bg;
    logic                   n_fixed;
    logic [INDEX_BITS-1:0]  n_fixed_idx;

    always_comb begin
        n_sel = (r_palette_select > PAL_LAST) ? PAL_DEFAULT : r_palette_select;
        n_n   = ({1'b0, PAL_LEN[n_sel]} > MAX_N) ? MAX_N : {1'b0, PAL_LEN[n_sel]};
        n_k   = INDEX_BITS'(n_n - (INDEX_BITS + 1)'(1));
        n_bg  = i_not_finite || (r_nodata_check && (i_sample == r_nodata_value));
        n_fixed     = 1'b1;
        n_fixed_idx = '0;
        priority if (r_range_high <= r_range_low) begin
            n_fixed_idx = n_k >> 1;
        end else if (i_sample <= r_range_low) begin
            n_fixed_idx = '0;
        end else if (i_sample >= r_range_high) begin
            n_fixed_idx = n_k;
        end else begin
            n_fixed = 1'b0;
        end
    end

    logic [2:0]             r1_sel;
    logic [INDEX_BITS-1:0]  r1_k;
    logic                   r1_bg;
    logic                   r1_fixed;
    logic [INDEX_BITS-1:0]  r1_fixed_idx;
    logic [SAMPLE_BITS-1:0] r1_diff;
    logic [SAMPLE_BITS-1:0] r1_span;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_sel       <= n_sel;
            r1_k         <= n_k;
            r1_bg        <= n_bg;
            r1_fixed     <= n_fixed;
            r1_fixed_idx <= n_fixed_idx;
            r1_diff      <= SAMPLE_BITS'(i_sample - r_range_low);
            r1_span      <= SAMPLE_BITS'(r_range_high - r_range_low);
        end
    end

    // Stage 2: scaled difference and span multiples.
    logic [2:0]            r2_sel;
    logic                  r2_bg;
    logic                  r2_fixed;
    logic [INDEX_BITS-1:0] r2_fixed_idx;
    logic [PW-1:0]         r2_diff_k;
    logic [PW-1:0]         r2_span_m [KMAX];

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_sel       <= r1_sel;
            r2_bg        <= r1_bg;
            r2_fixed     <= r1_fixed;
            r2_fixed_idx <= r1_fixed_idx;
            r2_diff_k    <= PW'(r1_diff) * PW'(r1_k);
            for (int j = 0; j < KMAX; j++) begin
                r2_span_m[j] <= PW'(r1_span) * PW'(j + 1);
            end
        end
    end

    // Stage 3: unless stage 1 fixed the index, the entry index is the number of span
    // multiples not above the scaled difference.
    logic [INDEX_BITS-1:0] n_count;

    always_comb begin
        n_count = '0;
        for (int j = 0; j < KMAX; j++) begin
            n_count = n_count + INDEX_BITS'(r2_diff_k >= r2_span_m[j]);
        end
    end

    logic [2:0]            r3_sel;
    logic                  r3_bg;
    logic [INDEX_BITS-1:0] r3_idx;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_sel <= r2_sel;
            r3_bg  <= r2_bg;
            r3_idx <= r2_fixed ? r2_fixed_idx : n_count;
        end
    end

    // Stage 4: palette ROM and output register.
    t_rgb n_color;

    assign n_color = PAL_ROM[r3_sel][r3_idx];

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            o_red         <= r3_bg ? BG_CHANNEL : n_color.red;
            o_green       <= r3_bg ? BG_CHANNEL : n_color.green;
            o_blue        <= r3_bg ? BG_CHANNEL : n_color.blue;
            o_color_index <= r3_bg ? '0 : r3_idx;
            o_background  <= r3_bg;
        end
    end

    assign o_valid = r4_valid;

endmodule

// ===== hdl/vcp_checker.sv =====
// ----------------------------------------------------------------------------
// vcp_checker: port-level checks for the colormap pixel pipeline
// Watches the top-level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
module vcp_checker #(
    parameter int SAMPLE_BITS        = vcp_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_PALETTE_COLORS = vcp_pkg::DEF_MAX_PALETTE_COLORS
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic signed [SAMPLE_BITS-1:0]  i_sample,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [7:0]                     o_red,
    input logic [7:0]                     o_green,
    input logic [7:0]                     o_blue,
    input logic [vcp_pkg::INDEX_BITS-1:0] o_color_index,
    input logic                           o_background
);
    import vcp_pkg::*;

    localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(MAX_PALETTE_COLORS - 1);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat presented straight after reset");

    a_background_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_background) |-> (o_red == BG_CHANNEL && o_green == BG_CHANNEL
            && o_blue == BG_CHANNEL && o_color_index == '0))
        else $error("background beat is not white with index zero");

    a_index_in_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_background) |-> (o_color_index <= LAST_INDEX))
        else $error("colour index beyond the palette");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_color_index) && $stable(o_background)))
        else $error("stalled result beat changed");

    a_stalled_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_sample)))
        else $error("stalled input beat changed");

endmodule

bind value_to_colormap_pixel_top vcp_checker #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .MAX_PALETTE_COLORS (MAX_PALETTE_COLORS)
) u_vcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_sample      (i_sample),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_color_index (o_color_index),
    .o_background  (o_background)
);

// ===== tb/value_to_colormap_pixel_top_tb.sv =====
// ----------------------------------------------------------------------------
// value_to_colormap_pixel_top_tb: self-checking bench for the colormap lookup
// Raster samples are driven under random idling and back-pressure. Each pixel
// is predicted from a private copy of the registers and palettes, and every
// output beat is compared field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module value_to_colormap_pixel_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import vcp_pkg::*;

    localparam int          PIPE_LATENCY  = 4;
    localparam int          SETTLE_CYCLES = PIPE_LATENCY + 4;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          STUCK_LIMIT   = 2000;
    localparam int          IDLE_PERCENT  = 32;
    localparam logic [2:0]  PAL_SPARE     = 3'd7;
    localparam logic [31:0] SAMPLE_MIN    = 32'h8000_0000;
    localparam logic [31:0] SAMPLE_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_ONE         = 32'h0001_0000;
    localparam logic [31:0] Q_HALF        = 32'h0000_8000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] index;
        logic       background;
    } t_pixel;

    localparam int COLOUR_COUNT [7] = '{5, 7, 3, 12, 12, 8, 9};

    localparam logic [23:0] COLOURS [7][12] = '{
        '{24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h003380, 24'h0080FF, 24'hCCB399, 24'h339933, 24'h1A661A, 24'h808080,
          24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h0000FF, 24'hFFFFFF, 24'hFF0000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h440154, 24'h482475, 24'h414487, 24'h355F8D, 24'h2A788E, 24'h21918C,
          24'h22A884, 24'h44BF70, 24'h70D456, 24'hA4E035, 24'hD8DF26, 24'hFDE725},
        '{24'h0D0887, 24'h381A9D, 24'h5C26AE, 24'h8128BB, 24'hA622BE, 24'hC316B9,
          24'hDA25AD, 24'hEA3E92, 24'hF2606D, 24'hF38546, 24'hF0AC23, 24'hFDDA20},
        '{24'h9E0142, 24'hE41A1C, 24'hFD9C28, 24'hFEE05D, 24'h85C408, 24'h08918C,
          24'h08498C, 24'h4F297A, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h67001F, 24'hB2182B, 24'hF06658, 24'hFDC0BE, 24'hF7F7FB, 24'hC6DBEF,
          24'h6AA3CD, 24'h313695, 24'h050C52, 24'h000000, 24'h000000, 24'h000000}
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic [2:0]  i_cfg_index  = '0;
    logic [31:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_sample     = '0;
    logic        i_not_finite = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_cfg_ready;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [3:0]  o_color_index;
    logic        o_background;

    logic signed [31:0] range_low      = 32'sd0;
    logic signed [31:0] range_high     = 32'sh0001_0000;
    logic               nodata_check   = 1'b0;
    logic signed [31:0] nodata_value   = 32'sd0;
    logic [2:0]         palette_select = PAL_DEFAULT;

    t_pixel pending_pixels [$];
    int     mismatches = 0;
    logic   steady     = 1'b0;
    logic   holding    = 1'b0;
    event   hold_go;

    value_to_colormap_pixel_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_not_finite  (i_not_finite),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_color_index (o_color_index),
        .o_background  (o_background)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int entries_of(input logic [2:0] sel);
        return COLOUR_COUNT[(sel > PAL_LAST) ? PAL_DEFAULT : sel];
    endfunction

    function automatic t_pixel expected_pixel(input logic signed [31:0] value,
                                              input logic nf);
        t_pixel      px;
        logic [2:0]  sel;
        logic [23:0] colour;
        longint      last;
        longint      idx;
        longint      diff;
        longint      span;
        if (nf || (nodata_check && value == nodata_value)) begin
            px = '{BG_CHANNEL, BG_CHANNEL, BG_CHANNEL, 4'd0, 1'b1};
            return px;
        end
        sel  = (palette_select > PAL_LAST) ? PAL_DEFAULT : palette_select;
        last = COLOUR_COUNT[sel] - 1;
        if (range_high <= range_low) begin
            idx = last / 2;
        end else if (value <= range_low) begin
            idx = 0;
        end else if (value >= range_high) begin
            idx = last;
        end else begin
            diff = longint'(value) - longint'(range_low);
            span = longint'(range_high) - longint'(range_low);
            idx  = (diff * last) / span;
        end
        colour = COLOURS[sel][idx];
        px = '{colour[23:16], colour[15:8], colour[7:0], idx[3:0], 1'b0};
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            report_mismatch("beat with nothing pending", longint'(o_color_index),
                            longint'(0));
            return;
        end
        want = pending_pixels.pop_front();
        if (o_red !== want.red)
            report_mismatch("red", longint'(o_red), longint'(want.red));
        if (o_green !== want.green)
            report_mismatch("green", longint'(o_green), longint'(want.green));
        if (o_blue !== want.blue)
            report_mismatch("blue", longint'(o_blue), longint'(want.blue));
        if (o_color_index !== want.index)
            report_mismatch("color_index", longint'(o_color_index), longint'(want.index));
        if (o_background !== want.background)
            report_mismatch("background", longint'(o_background),
                            longint'(want.background));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_pixel();
        end
        if (holding || (!steady && $urandom_range(0, 99) < IDLE_PERCENT)) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always begin
        @(hold_go);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (i_rst_n);
        while (quiet_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    task automatic await_idle();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [31:0] value, input logic nf);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_sample     <= value;
        i_not_finite <= nf;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back(expected_pixel(value, nf));
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] data);
        await_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_RANGE_LOW:      range_low      = data;
            CFG_RANGE_HIGH:     range_high     = data;
            CFG_NODATA_CHECK:   nodata_check   = data[0];
            CFG_NODATA_VALUE:   nodata_value   = data;
            CFG_PALETTE_SELECT: palette_select = data[2:0];
            default: ;
        endcase
    endtask

    function automatic void pick_sample(output logic [31:0] value, output logic nf);
        int unsigned roll;
        longint      span;
        int          last;
        roll  = $urandom_range(0, 99);
        nf    = 1'b0;
        value = $urandom;
        span  = longint'(range_high) - longint'(range_low);
        last  = entries_of(palette_select) - 1;
        if (roll < 50) begin
            if (span > 0) begin
                value = 32'(longint'(range_low) + (longint'($urandom) % (span + 1)));
            end
        end else if (roll < 62) begin
            if (span > 0) begin
                value = 32'(longint'(range_low) +
                            (span * longint'($urandom_range(0, last))) / last +
                            longint'($urandom_range(0, 1)));
            end
        end else if (roll < 72) begin
            value = ($urandom_range(0, 1) ? range_low : range_high) +
                    $urandom_range(0, 4) - 2;
        end else if (roll < 80) begin
            value = nodata_value;
        end else if (roll < 88) begin
            nf = 1'b1;
        end
    endfunction

    task automatic configure_random();
        logic [31:0] low;
        logic [31:0] high;
        case ($urandom_range(0, 5))
            0: begin
                low  = $urandom;
                high = $urandom;
            end
            1: begin
                low  = ($urandom_range(0, 200) - 100) << 16;
                high = low + ($urandom_range(1, 200) << 16);
            end
            2: begin
                low  = SAMPLE_MIN;
                high = SAMPLE_MAX;
            end
            3: begin
                low  = $urandom;
                high = low;
            end
            4: begin
                low  = $urandom;
                high = low + $urandom_range(1, 40);
            end
            default: begin
                low  = $urandom_range(0, 1) ? SAMPLE_MIN : $urandom;
                high = $urandom_range(0, 1) ? SAMPLE_MAX : $urandom;
            end
        endcase
        write_register(CFG_RANGE_LOW, low);
        write_register(CFG_RANGE_HIGH, high);
        write_register(CFG_NODATA_CHECK, $urandom);
        write_register(CFG_NODATA_VALUE,
                       $urandom_range(0, 1) ? $urandom : low + $urandom_range(0, 3));
        write_register(CFG_PALETTE_SELECT, $urandom);
        if ($urandom_range(0, 3) == 0) begin
            write_register(CFG_INDEX_BITS'($urandom_range(CFG_PALETTE_SELECT + 1,
                                          (1 << CFG_INDEX_BITS) - 1)), $urandom);
        end
    endtask

    task automatic send_random_samples(input int count);
        logic [31:0] value;
        logic        nf;
        repeat (count) begin
            pick_sample(value, nf);
            send_sample(value, nf);
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(32'd0, 1'b0);
        send_sample(Q_HALF, 1'b0);
        send_sample(Q_ONE - 1, 1'b0);
        send_sample(Q_ONE, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_special_cases();
        write_register(CFG_NODATA_CHECK, 32'd1);
        write_register(CFG_NODATA_VALUE, Q_ONE + Q_HALF);
        send_sample(Q_ONE + Q_HALF, 1'b0);
        send_sample(Q_ONE + Q_HALF + 1, 1'b0);
        send_sample(Q_ONE + Q_HALF, 1'b1);
        write_register(CFG_NODATA_CHECK, 32'd0);
        send_sample(Q_ONE + Q_HALF, 1'b0);
        write_register(CFG_RANGE_LOW, Q_ONE);
        write_register(CFG_RANGE_HIGH, 32'd0);
        send_sample(Q_HALF, 1'b0);
        write_register(CFG_RANGE_HIGH, Q_ONE);
        send_sample(Q_ONE, 1'b0);
        write_register(CFG_RANGE_LOW, SAMPLE_MIN);
        write_register(CFG_RANGE_HIGH, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(32'd0, 1'b0);
        send_sample(SAMPLE_MAX - 1, 1'b0);
        write_register(CFG_PALETTE_SELECT, {29'd0, PAL_SPARE});
        send_sample(SAMPLE_MIN + 1, 1'b0);
        send_sample(32'hC000_0000, 1'b0);
        for (int idx = CFG_PALETTE_SELECT + 1; idx < (1 << CFG_INDEX_BITS); idx++) begin
            write_register(CFG_INDEX_BITS'(idx), $urandom);
        end
        send_sample(32'h4000_0000, 1'b0);
    endtask

    task automatic test_random_settings();
        repeat (8) begin
            configure_random();
            send_random_samples(35);
        end
    endtask

    task automatic test_steady_stream();
        configure_random();
        steady = 1'b1;
        send_random_samples(60);
        steady = 1'b0;
    endtask

    task automatic test_output_hold();
        configure_random();
        steady = 1'b1;
        -> hold_go;
        send_random_samples(30);
        steady = 1'b0;
    endtask

    task automatic test_sender_pause();
        configure_random();
        send_random_samples(12);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        send_random_samples(12);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_special_cases();
        test_random_settings();
        test_steady_stream();
        test_output_hold();
        test_sender_pause();
        await_idle();
        if (pending_pixels.size() != 0) begin
            report_mismatch("pixels never delivered", longint'(pending_pixels.size()),
                            longint'(0));
        end
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
